// ===== hdl/lmss_pkg.sv =====
// Shared constants for the modal split softmax block: field widths,
// fixed-point constants, register indexes and pipeline stage counts.
// No dependencies.
package lmss_pkg;

  localparam int MODES = 4;
  localparam int MODE_W = 2;

  localparam int DIST_W = 32;
  localparam int PROB_W = 17;
  localparam int WF_W = 16;
  localparam int COEF_W = 48;
  localparam int CFG_W = 64;
  localparam int IDX_W = 3;
  localparam int FACT_W = 16;

  localparam logic [IDX_W-1:0] REG_FACTOR = 3'd4;

  // log2 unit
  localparam int Z_W = 31;
  localparam int LG_W = 21;
  localparam int SQ_STEPS = 16;
  localparam int LNP_W = LG_W + 16;
  localparam int LNK_W = 22;

  // utilities
  localparam int UTIL_W = 24;
  localparam int UP_W = UTIL_W + LNK_W;
  localparam int UTIL_MAX = 8388607;
  localparam int UTIL_MIN = -8388608;

  localparam int Q16_HALF = 32768;
  localparam int LN2_Q16 = 45426;
  localparam int LN16_Q16 = 181704;

  // exp unit
  localparam int N_W = 9;
  localparam int REM0_W = 17;
  localparam int R_W = 30;
  localparam int T_W = 31;
  localparam int S_W = 31;
  localparam int EXP_W = 17;
  localparam int EXP_NLIM = 18;
  localparam int TERMS = 12;
  localparam int Q30_ONE = 1 << 30;
  localparam logic [16:0] INV_LN2 = 17'(64'h1_0000_0000 / 64'd45426);
  localparam logic [32:0] RECIP [1:TERMS] = '{
    33'(64'h1_0000_0000 / 64'd1),  33'(64'h1_0000_0000 / 64'd2),
    33'(64'h1_0000_0000 / 64'd3),  33'(64'h1_0000_0000 / 64'd4),
    33'(64'h1_0000_0000 / 64'd5),  33'(64'h1_0000_0000 / 64'd6),
    33'(64'h1_0000_0000 / 64'd7),  33'(64'h1_0000_0000 / 64'd8),
    33'(64'h1_0000_0000 / 64'd9),  33'(64'h1_0000_0000 / 64'd10),
    33'(64'h1_0000_0000 / 64'd11), 33'(64'h1_0000_0000 / 64'd12)
  };
  localparam int EXP_LAT = 3 + 3 * TERMS + 1;

  // share divider and weighting
  localparam int SUM_W = EXP_W + $clog2(MODES);
  localparam int REM_W = SUM_W + PROB_W;
  localparam int DIV_STEPS = PROB_W;
  localparam int WP_W = PROB_W + FACT_W;
  localparam int WS_W = WP_W + $clog2(MODES);

  localparam int PIPE_LEN = 1 + SQ_STEPS + 1 + 2 + 2 + EXP_LAT + 2 + DIV_STEPS + 2;

endpackage

// ===== hdl/lmss_if.sv =====
// Channel interfaces of the modal split softmax block: distance input
// and per-mode result output. Depends on lmss_pkg.
interface lmss_in_if;
  logic                          valid;
  logic                          ready;
  logic [lmss_pkg::DIST_W-1:0]   distance;

  modport source (output valid, output distance, input ready);
  modport sink (input valid, input distance, output ready);
endinterface

interface lmss_out_if;
  logic                          valid;
  logic                          ready;
  logic [lmss_pkg::MODE_W-1:0]   mode;
  logic [lmss_pkg::PROB_W-1:0]   probability;
  logic [lmss_pkg::WF_W-1:0]     weighted_factor;
  logic                          status;
  logic                          last;

  modport source (output valid, output mode, output probability, output weighted_factor,
                  output status, output last, input ready);
  modport sink (input valid, input mode, input probability, input weighted_factor,
                input status, input last, output ready);
endinterface

// ===== hdl/logit_modal_split_softmax.sv =====
// Multinomial logit modal split: distance in, one softmax share per mode out.
// Depends on lmss_pkg, lmss_if (lmss_in_if, lmss_out_if) and lmss_exp.
//
// Usage:
//   item   : one distance (1/16 km) per transfer, valid/ready.
//   result : one transfer per mode in mode order, last set on the final one,
//            which also carries the weighted emission factor. A zero distance
//            gives a single result with status set.
//   wr_en/wr_index/wr_data : register writes, taken on any cycle with wr_en;
//            write only while no item is in flight.
// The pipeline is 83 stages deep, among them 16 squaring stages for the
// logarithm, 40 for the exp lanes (12 Taylor terms of three stages each)
// and 17 for the restoring share divider. One item enters per cycle while
// the pipeline moves; the sustained item rate is set by the result
// channel, which emits one share per cycle while the receiver is ready.
// Reset empties the pipeline and clears all registers to zero. When the
// receiver stalls, the output stage holds its result and the whole pipeline
// freezes once the finished item waits; nothing is dropped or repeated.
module logit_modal_split_softmax (
  input  logic                        clk,
  input  logic                        rst,
  lmss_in_if.sink                     item,
  lmss_out_if.source                  result,
  input  logic                        wr_en,
  input  logic [lmss_pkg::IDX_W-1:0]  wr_index,
  input  logic [lmss_pkg::CFG_W-1:0]  wr_data
);
  import lmss_pkg::*;

  logic [COEF_W-1:0]         coef [MODES];
  logic [CFG_W-1:0]          factor;

  logic                      adv;
  logic [PIPE_LEN-1:0]       vl;
  logic [PIPE_LEN-1:0]       zl;

  logic [4:0]                lead;
  logic [DIST_W+Z_W-2:0]     dsh;
  logic [Z_W-1:0]            sq_z [SQ_STEPS+1];
  logic [LG_W-1:0]           sq_lg [SQ_STEPS+1];
  logic [2*Z_W-1:0]          sq_prod [SQ_STEPS];
  logic [Z_W:0]              sq_zz [SQ_STEPS];

  logic [LNP_W-1:0]          ln_prod;
  logic signed [LNK_W-1:0]   lnk;

  logic signed [UP_W-1:0]    u_prod [MODES];
  logic signed [UP_W-1:0]    u_sum [MODES];
  logic signed [UTIL_W-1:0]  u_next [MODES];
  logic signed [UTIL_W-1:0]  u [MODES];
  logic signed [UTIL_W-1:0]  u_m [MODES];
  logic signed [UTIL_W-1:0]  umax_next;
  logic signed [UTIL_W-1:0]  umax;
  logic [UTIL_W-1:0]         x [MODES];

  logic [EXP_W-1:0]          e [MODES];
  logic [EXP_W-1:0]          e_s [MODES];
  logic [SUM_W-1:0]          e_tot_next;
  logic [SUM_W-1:0]          e_tot;

  logic [REM_W-1:0]          dv_rem [DIV_STEPS+1][MODES];
  logic [PROB_W-1:0]         dv_q [DIV_STEPS+1][MODES];
  logic [SUM_W-1:0]          dv_s [DIV_STEPS+1];
  logic [REM_W:0]            dv_trial [DIV_STEPS][MODES];

  logic [WP_W-1:0]           wp [MODES];
  logic [PROB_W-1:0]         wp_p [MODES];
  logic [WS_W-1:0]           w_sum;
  logic [WF_W-1:0]           wf_next;
  logic [WF_W-1:0]           wf;
  logic [PROB_W-1:0]         w_p [MODES];

  logic                      ser_valid;
  logic [MODE_W-1:0]         ser_cnt;
  logic [PROB_W-1:0]         ser_p [MODES];
  logic [WF_W-1:0]           ser_wf;
  logic                      ser_zero;
  logic                      ser_last;
  logic                      ser_take;
  logic                      out_fire;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < MODES; k++) begin
        coef[k] <= '0;
      end
      factor <= '0;
    end else if (wr_en) begin
      if (wr_index == REG_FACTOR) begin
        factor <= wr_data;
      end else if (wr_index < IDX_W'(MODES)) begin
        coef[wr_index[MODE_W-1:0]] <= wr_data[COEF_W-1:0];
      end
    end
  end

  // flow control
  assign ser_last = ser_zero || (ser_cnt == MODE_W'(MODES - 1));
  assign out_fire = ser_valid && result.ready;
  assign ser_take = !ser_valid || (out_fire && ser_last);
  assign adv = !vl[PIPE_LEN-1] || ser_take;
  assign item.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vl <= '0;
    end else if (adv) begin
      vl <= {vl[PIPE_LEN-2:0], item.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      zl <= {zl[PIPE_LEN-2:0], item.distance == '0};
    end
  end

  // log2: normalize, then one squaring per stage
  always_comb begin
    lead = '0;
    for (int i = 0; i < DIST_W; i++) begin
      if (item.distance[i]) begin
        lead = 5'(i);
      end
    end
    dsh = {item.distance, (Z_W-1)'(0)} >> lead;
    for (int i = 0; i < SQ_STEPS; i++) begin
      sq_prod[i] = sq_z[i] * sq_z[i];
      sq_zz[i] = (Z_W+1)'(sq_prod[i] >> 30);
    end
    ln_prod = LNP_W'(sq_lg[SQ_STEPS]) * LNP_W'(LN2_Q16) + LNP_W'(Q16_HALF);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_z[0] <= dsh[Z_W-1:0];
      sq_lg[0] <= {lead, 16'd0};
      for (int i = 0; i < SQ_STEPS; i++) begin
        if (sq_zz[i][Z_W]) begin
          sq_z[i+1] <= sq_zz[i][Z_W:1];
          sq_lg[i+1] <= sq_lg[i] | (LG_W'(1) << (SQ_STEPS - 1 - i));
        end else begin
          sq_z[i+1] <= sq_zz[i][Z_W-1:0];
          sq_lg[i+1] <= sq_lg[i];
        end
      end
      lnk <= $signed({1'b0, ln_prod[LNP_W-1:16]}) - LNK_W'(LN16_Q16);
    end
  end

  // utilities, maximum, offsets
  always_comb begin
    for (int k = 0; k < MODES; k++) begin
      u_sum[k] = $signed(coef[k][COEF_W-1:UTIL_W]) + ((u_prod[k] + Q16_HALF) >>> 16);
      if (u_sum[k] > UTIL_MAX) begin
        u_next[k] = UTIL_W'(UTIL_MAX);
      end else if (u_sum[k] < UTIL_MIN) begin
        u_next[k] = UTIL_W'(UTIL_MIN);
      end else begin
        u_next[k] = UTIL_W'(u_sum[k]);
      end
    end
    umax_next = u[0];
    for (int k = 1; k < MODES; k++) begin
      if (u[k] > umax_next) begin
        umax_next = u[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < MODES; k++) begin
        u_prod[k] <= $signed(coef[k][UTIL_W-1:0]) * lnk;
        u[k] <= u_next[k];
        u_m[k] <= u[k];
        x[k] <= UTIL_W'(umax - u_m[k]);
      end
      umax <= umax_next;
    end
  end

  for (genvar k = 0; k < MODES; k++) begin : g_lane
    lmss_exp u_exp (
      .clk (clk),
      .en  (adv),
      .x   (x[k]),
      .e   (e[k])
    );
  end

  // share division: one quotient bit per stage
  always_comb begin
    e_tot_next = '0;
    for (int k = 0; k < MODES; k++) begin
      e_tot_next = e_tot_next + SUM_W'(e[k]);
    end
    for (int j = 0; j < DIV_STEPS; j++) begin
      for (int k = 0; k < MODES; k++) begin
        dv_trial[j][k] = {1'b0, dv_rem[j][k]} -
                         ((REM_W+1)'(dv_s[j]) << (DIV_STEPS - 1 - j));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_tot <= e_tot_next;
      dv_s[0] <= e_tot;
      for (int k = 0; k < MODES; k++) begin
        e_s[k] <= e[k];
        dv_rem[0][k] <= (REM_W'(e_s[k]) << 16) + REM_W'(e_tot >> 1);
        dv_q[0][k] <= '0;
      end
      for (int j = 0; j < DIV_STEPS; j++) begin
        dv_s[j+1] <= dv_s[j];
        for (int k = 0; k < MODES; k++) begin
          if (!dv_trial[j][k][REM_W]) begin
            dv_rem[j+1][k] <= dv_trial[j][k][REM_W-1:0];
            dv_q[j+1][k] <= dv_q[j][k] | (PROB_W'(1) << (DIV_STEPS - 1 - j));
          end else begin
            dv_rem[j+1][k] <= dv_rem[j][k];
            dv_q[j+1][k] <= dv_q[j][k];
          end
        end
      end
    end
  end

  // weighted emission factor
  always_comb begin
    w_sum = WS_W'(Q16_HALF);
    for (int k = 0; k < MODES; k++) begin
      w_sum = w_sum + WS_W'(wp[k]);
    end
    if ((w_sum >> 16) > WS_W'(16'hFFFF)) begin
      wf_next = '1;
    end else begin
      wf_next = WF_W'(w_sum >> 16);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < MODES; k++) begin
        wp[k] <= dv_q[DIV_STEPS][k] * factor[FACT_W*k +: FACT_W];
        wp_p[k] <= dv_q[DIV_STEPS][k];
        w_p[k] <= wp_p[k];
      end
      wf <= wf_next;
    end
  end

  // output serializer
  always_ff @(posedge clk) begin
    if (rst) begin
      ser_valid <= 1'b0;
      ser_cnt <= '0;
    end else if (ser_take) begin
      ser_valid <= vl[PIPE_LEN-1];
      ser_cnt <= '0;
    end else if (out_fire) begin
      ser_cnt <= ser_cnt + MODE_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ser_take && vl[PIPE_LEN-1]) begin
      ser_p <= w_p;
      ser_wf <= wf;
      ser_zero <= zl[PIPE_LEN-1];
    end
  end

  assign result.valid = ser_valid;
  assign result.mode = ser_cnt;
  assign result.probability = ser_zero ? '0 : ser_p[ser_cnt];
  assign result.weighted_factor = (ser_last && !ser_zero) ? ser_wf : '0;
  assign result.status = ser_zero;
  assign result.last = ser_last;

endmodule

// ===== hdl/lmss_exp.sv =====
// One lane of exp(-x): range reduction by ln2, 12-term Taylor series and
// final scaling, fully pipelined with a common enable. Depends on lmss_pkg.
module lmss_exp (
  input  logic                         clk,
  input  logic                         en,
  input  logic [lmss_pkg::UTIL_W-1:0]  x,
  output logic [lmss_pkg::EXP_W-1:0]   e
);
  import lmss_pkg::*;

  typedef struct packed {
    logic [T_W-1:0] t;
    logic [T_W-1:0] q;
    logic [R_W-1:0] r;
    logic [S_W-1:0] s;
    logic [N_W-1:0] n;
  } tay_t;

  logic [UTIL_W+16:0]   n_prod;
  logic [UTIL_W-1:0]    x0;
  logic [UTIL_W-1:0]    x1;
  logic [N_W-1:0]       n_sel;
  logic [N_W-1:0]       n1;
  logic [UTIL_W-1:0]    nm1;
  logic [REM0_W-1:0]    rem0;
  tay_t                 c0_next;

  tay_t                 st_a [1:TERMS];
  tay_t                 st_b [1:TERMS];
  tay_t                 st_c [0:TERMS];
  tay_t                 a_next [1:TERMS];
  tay_t                 b_next [1:TERMS];
  tay_t                 c_next [1:TERMS];
  logic [T_W+R_W-1:0]   ta_prod [1:TERMS];
  logic [T_W+32:0]      tb_prod [1:TERMS];
  logic [T_W-1:0]       tc_chk [1:TERMS];
  logic [T_W-1:0]       tc_q [1:TERMS];

  logic [S_W:0]         e_sum;
  logic [5:0]           e_sh;
  logic [EXP_W-1:0]     e_next;

  always_comb begin
    n_sel = N_W'(n_prod >> 32);
    rem0 = REM0_W'(x1 - nm1);
    c0_next.t = T_W'(Q30_ONE);
    c0_next.s = S_W'(Q30_ONE);
    c0_next.q = '0;
    if (rem0 >= REM0_W'(LN2_Q16)) begin
      c0_next.n = n1 + N_W'(1);
      c0_next.r = R_W'(rem0 - REM0_W'(LN2_Q16)) << 14;
    end else begin
      c0_next.n = n1;
      c0_next.r = R_W'(rem0) << 14;
    end
  end

  always_comb begin
    for (int k = 1; k <= TERMS; k++) begin
      ta_prod[k] = st_c[k-1].t * st_c[k-1].r;
      tb_prod[k] = st_a[k].t * RECIP[k];
      tc_chk[k] = st_b[k].t - T_W'(st_b[k].q * T_W'(k));
      tc_q[k] = st_b[k].q + T_W'(tc_chk[k] >= T_W'(k));
      a_next[k] = st_c[k-1];
      a_next[k].t = T_W'(ta_prod[k] >> 30);
      b_next[k] = st_a[k];
      b_next[k].q = T_W'(tb_prod[k] >> 32);
      c_next[k] = st_b[k];
      c_next[k].t = tc_q[k];
      if ((k & 1) == 1) begin
        c_next[k].s = st_b[k].s - tc_q[k];
      end else begin
        c_next[k].s = st_b[k].s + tc_q[k];
      end
    end
  end

  // (s + 2^(13+n)) >> (14+n); shares beyond 17 halvings round to zero
  always_comb begin
    e_sh = 6'(st_c[TERMS].n[4:0]) + 6'd14;
    e_sum = {1'b0, st_c[TERMS].s} + ((S_W+1)'(1) << (e_sh - 6'd1));
    if (st_c[TERMS].n >= N_W'(EXP_NLIM)) begin
      e_next = '0;
    end else begin
      e_next = EXP_W'(e_sum >> e_sh);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_prod <= x * INV_LN2;
      x0 <= x;
      x1 <= x0;
      n1 <= n_sel;
      nm1 <= UTIL_W'(n_sel) * UTIL_W'(LN2_Q16);
      st_c[0] <= c0_next;
      for (int k = 1; k <= TERMS; k++) begin
        st_a[k] <= a_next[k];
        st_b[k] <= b_next[k];
        st_c[k] <= c_next[k];
      end
      e <= e_next;
    end
  end

endmodule

// ===== hdl/lmss_chk.sv =====
// Port-level checker for the modal split softmax block, bound to the top
// level. Depends on lmss_pkg and logit_modal_split_softmax.
module lmss_chk (
  input logic                        clk,
  input logic                        rst,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [lmss_pkg::MODE_W-1:0] mode,
  input logic [lmss_pkg::PROB_W-1:0] probability,
  input logic [lmss_pkg::WF_W-1:0]   weighted_factor,
  input logic                        status,
  input logic                        last
);
  import lmss_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(mode) && $stable(probability))
    else $error("result changed while stalled");

  a_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last |=> out_valid && (mode == $past(mode) + 2'd1))
    else $error("mode sequence broken");

  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> last && mode == '0 && probability == '0 && weighted_factor == '0)
    else $error("bad invalid-distance result");

  a_wf: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> weighted_factor == '0)
    else $error("weighted factor on non-final result");

  a_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && last && !status |-> mode == MODE_W'(MODES - 1))
    else $error("last flag on wrong mode");

endmodule

bind logit_modal_split_softmax lmss_chk u_lmss_chk (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (result.valid),
  .out_ready       (result.ready),
  .mode            (result.mode),
  .probability     (result.probability),
  .weighted_factor (result.weighted_factor),
  .status          (result.status),
  .last            (result.last)
);
